// ===== rtl/core/hfv_pkg.sv =====
`default_nettype none
package hfv_pkg;

    localparam int CHALLENGE_BYTES = 16;
    localparam int RESPONSE_BYTES  = 32;

    localparam int HDR_BYTES   = 8;
    localparam int STORE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 6;
    localparam int COUNT_MAX   = 63;

    localparam int CH_ITEMS = (CHALLENGE_BYTES > STORE_DEPTH) ? STORE_DEPTH : CHALLENGE_BYTES;
    localparam int RS_ITEMS = (RESPONSE_BYTES > STORE_DEPTH) ? STORE_DEPTH : RESPONSE_BYTES;

    localparam logic [CNT_W-1:0] LEN_REQUEST   = CNT_W'(HDR_BYTES);
    localparam logic [CNT_W-1:0] LEN_CHALLENGE = CNT_W'(HDR_BYTES + CHALLENGE_BYTES);
    localparam logic [CNT_W-1:0] LEN_RESPONSE  = CNT_W'(HDR_BYTES + RESPONSE_BYTES);
    localparam logic [CNT_W-1:0] LEN_STATUS    = CNT_W'(HDR_BYTES + 4);

    localparam logic [CNT_W-1:0] POS_MAGIC_LAST = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_VERSION    = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_TYPE       = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_SERVICE    = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_RESERVED   = CNT_W'(7);
    localparam logic [CNT_W-1:0] POS_HDR        = CNT_W'(HDR_BYTES);
    localparam logic [CNT_W-1:0] POS_STATUS_END = CNT_W'(HDR_BYTES + 3);
    localparam logic [CNT_W-1:0] POS_STORE_END  = CNT_W'(HDR_BYTES + STORE_DEPTH - 1);
    localparam logic [CNT_W-1:0] POS_SAT        = CNT_W'(COUNT_MAX);

    typedef enum logic [2:0] {
        CFG_MAGIC     = 3'd0,
        CFG_VERSION   = 3'd1,
        CFG_SERVICE_A = 3'd2,
        CFG_SERVICE_B = 3'd3,
        CFG_REQUEST   = 3'd4,
        CFG_CHALLENGE = 3'd5,
        CFG_RESPONSE  = 3'd6,
        CFG_STATUS    = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_SHORT   = 3'd1,
        ERR_MAGIC   = 3'd2,
        ERR_VERSION = 3'd3,
        ERR_SERVICE = 3'd4,
        ERR_LENGTH  = 3'd5,
        ERR_TYPE    = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        KIND_REQUEST   = 3'd0,
        KIND_CHALLENGE = 3'd1,
        KIND_RESPONSE  = 3'd2,
        KIND_STATUS    = 3'd3,
        KIND_UNKNOWN   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  protocol_version;
        logic [7:0]  service_a;
        logic [7:0]  service_b;
        logic [7:0]  code_request;
        logic [7:0]  code_challenge;
        logic [7:0]  code_response;
        logic [7:0]  code_status;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W:0]   addr;
        logic [7:0]        data;
    } wr_t;

    typedef struct packed {
        logic              ok;
        err_t              err;
        logic [1:0]        mk;
        logic [7:0]        sid;
        logic [31:0]       st;
        logic              last;
        logic [CNT_W-1:0]  n;
        logic              bank;
    } verdict_t;

    typedef struct packed {
        logic        item_kind;
        logic        frame_ok;
        logic [2:0]  error_code;
        logic [1:0]  message_kind;
        logic [7:0]  service_id;
        logic [31:0] status_word;
        logic [7:0]  payload_byte;
        logic        run_last;
    } item_t;

    function automatic kind_t decode_kind(logic [7:0] t, cfg_t c);
        if (t == c.code_request)   return KIND_REQUEST;
        if (t == c.code_challenge) return KIND_CHALLENGE;
        if (t == c.code_response)  return KIND_RESPONSE;
        if (t == c.code_status)    return KIND_STATUS;
        return KIND_UNKNOWN;
    endfunction

    function automatic logic [CNT_W-1:0] length_for_kind(kind_t k);
        case (k)
            KIND_CHALLENGE: return LEN_CHALLENGE;
            KIND_RESPONSE:  return LEN_RESPONSE;
            KIND_STATUS:    return LEN_STATUS;
            default:        return LEN_REQUEST;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] items_for_kind(kind_t k);
        case (k)
            KIND_CHALLENGE: return CNT_W'(CH_ITEMS);
            KIND_RESPONSE:  return CNT_W'(RS_ITEMS);
            default:        return '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hfv_cfg.sv =====
`default_nettype none
module hfv_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output hfv_pkg::cfg_t    cfg
);

    hfv_pkg::cfg_t cfg_reg;
    hfv_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (hfv_pkg::cfg_index_t'(cfg_index))
                hfv_pkg::CFG_MAGIC:     cfg_next.magic_word       = cfg_data;
                hfv_pkg::CFG_VERSION:   cfg_next.protocol_version = cfg_data[7:0];
                hfv_pkg::CFG_SERVICE_A: cfg_next.service_a        = cfg_data[7:0];
                hfv_pkg::CFG_SERVICE_B: cfg_next.service_b        = cfg_data[7:0];
                hfv_pkg::CFG_REQUEST:   cfg_next.code_request     = cfg_data[7:0];
                hfv_pkg::CFG_CHALLENGE: cfg_next.code_challenge   = cfg_data[7:0];
                hfv_pkg::CFG_RESPONSE:  cfg_next.code_response    = cfg_data[7:0];
                hfv_pkg::CFG_STATUS:    cfg_next.code_status      = cfg_data[7:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word       <= 32'd0;
            cfg_reg.protocol_version <= 8'd0;
            cfg_reg.service_a        <= 8'd0;
            cfg_reg.service_b        <= 8'd1;
            cfg_reg.code_request     <= 8'd0;
            cfg_reg.code_challenge   <= 8'd1;
            cfg_reg.code_response    <= 8'd2;
            cfg_reg.code_status      <= 8'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/core/hfv_parse.sv =====
`default_nettype none
module hfv_parse (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hfv_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [7:0]      byte_in,
    input  wire logic            frame_end,
    input  wire logic            take_ok,
    output logic                 start,
    output hfv_pkg::verdict_t    verdict,
    output hfv_pkg::wr_t         wr
);

    logic [hfv_pkg::CNT_W-1:0] count_reg, count_next;
    logic [31:0]               magic_reg, magic_next;
    hfv_pkg::err_t             err_reg, err_next;
    logic [7:0]                type_reg, type_next;
    logic [7:0]                svc_reg, svc_next;
    logic [31:0]               status_reg, status_next;
    logic                      bank_reg;

    logic                      acc;
    logic                      live;
    logic [31:0]               magic_shifted;
    logic [hfv_pkg::CNT_W-1:0] store_idx;
    hfv_pkg::kind_t            kind;
    hfv_pkg::err_t             final_err;
    logic                      ok;

    assign in_stall = in_valid && frame_end && !take_ok;
    assign acc      = in_valid && !in_stall;
    assign live     = count_reg != hfv_pkg::POS_SAT;
    assign magic_shifted = {magic_reg[23:0], byte_in};
    assign store_idx     = count_reg - hfv_pkg::POS_HDR;

    always_comb
    begin
        count_next  = count_reg;
        magic_next  = magic_reg;
        err_next    = err_reg;
        type_next   = type_reg;
        svc_next    = svc_reg;
        status_next = status_reg;
        if (live)
        begin
            count_next = count_reg + hfv_pkg::CNT_W'(1);
            if (count_reg < hfv_pkg::CNT_W'(4))
                magic_next = magic_shifted;
            if (count_reg == hfv_pkg::POS_MAGIC_LAST && magic_shifted != cfg.magic_word
                && err_next == hfv_pkg::ERR_NONE)
                err_next = hfv_pkg::ERR_MAGIC;
            if (count_reg == hfv_pkg::POS_VERSION && byte_in != cfg.protocol_version
                && err_next == hfv_pkg::ERR_NONE)
                err_next = hfv_pkg::ERR_VERSION;
            if (count_reg == hfv_pkg::POS_TYPE)
                type_next = byte_in;
            if (count_reg == hfv_pkg::POS_SERVICE)
            begin
                svc_next = byte_in;
                if (byte_in != cfg.service_a && byte_in != cfg.service_b
                    && err_next == hfv_pkg::ERR_NONE)
                    err_next = hfv_pkg::ERR_SERVICE;
            end
            if (count_reg == hfv_pkg::POS_RESERVED)
            begin
                if (byte_in != 8'd0 && err_next == hfv_pkg::ERR_NONE)
                    err_next = hfv_pkg::ERR_LENGTH;
                if (hfv_pkg::decode_kind(type_reg, cfg) == hfv_pkg::KIND_UNKNOWN
                    && err_next == hfv_pkg::ERR_NONE)
                    err_next = hfv_pkg::ERR_TYPE;
            end
            if (count_reg inside {[hfv_pkg::POS_HDR:hfv_pkg::POS_STATUS_END]})
                status_next = {status_reg[23:0], byte_in};
        end
    end

    always_comb
    begin
        kind      = hfv_pkg::decode_kind(type_next, cfg);
        final_err = err_next;
        if (count_next < hfv_pkg::POS_HDR)
            final_err = hfv_pkg::ERR_SHORT;
        else if (err_next == hfv_pkg::ERR_NONE && count_next != hfv_pkg::length_for_kind(kind))
            final_err = hfv_pkg::ERR_LENGTH;
        ok = final_err == hfv_pkg::ERR_NONE;

        verdict.ok   = ok;
        verdict.err  = final_err;
        verdict.mk   = ok ? kind[1:0] : 2'd0;
        verdict.sid  = ok ? svc_next : 8'd0;
        verdict.st   = (ok && kind == hfv_pkg::KIND_STATUS) ? status_next : 32'd0;
        verdict.n    = ok ? hfv_pkg::items_for_kind(kind) : '0;
        verdict.last = verdict.n == '0;
        verdict.bank = bank_reg;
    end

    assign start = acc && frame_end;

    always_comb
    begin
        wr.en   = acc && live
                  && (count_reg inside {[hfv_pkg::POS_HDR:hfv_pkg::POS_STORE_END]});
        wr.addr = {bank_reg, store_idx[hfv_pkg::ADDR_W-1:0]};
        wr.data = byte_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            magic_reg  <= 32'd0;
            err_reg    <= hfv_pkg::ERR_NONE;
            type_reg   <= 8'd0;
            svc_reg    <= 8'd0;
            status_reg <= 32'd0;
            bank_reg   <= 1'b0;
        end
        else if (acc)
        begin
            if (frame_end)
            begin
                count_reg  <= '0;
                magic_reg  <= 32'd0;
                err_reg    <= hfv_pkg::ERR_NONE;
                type_reg   <= 8'd0;
                svc_reg    <= 8'd0;
                status_reg <= 32'd0;
                bank_reg   <= !bank_reg;
            end
            else
            begin
                count_reg  <= count_next;
                magic_reg  <= magic_next;
                err_reg    <= err_next;
                type_reg   <= type_next;
                svc_reg    <= svc_next;
                status_reg <= status_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/hfv_drain.sv =====
`default_nettype none
module hfv_drain (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hfv_pkg::wr_t       wr,
    input  wire logic               start,
    input  wire hfv_pkg::verdict_t  verdict,
    output logic                    take_ok,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output hfv_pkg::item_t          item
);

    logic [7:0] mem [2*hfv_pkg::STORE_DEPTH];
    logic [7:0] rdata_reg;

    logic [hfv_pkg::CNT_W-1:0]  left_reg;
    logic [hfv_pkg::ADDR_W-1:0] idx_reg;
    logic                       bank_reg;
    logic [1:0]                 mk_reg;
    logic [7:0]                 sid_reg;

    logic           s1_valid_reg;
    logic           s1_pay_reg;
    hfv_pkg::item_t s1_reg, s1_next;
    hfv_pkg::item_t s1_item;

    logic           out_valid_reg, out_valid_next;
    hfv_pkg::item_t out_reg, out_next;
    logic           skid_valid_reg, skid_valid_next;
    hfv_pkg::item_t skid_reg, skid_next;

    logic [1:0] occ;
    logic       pop;
    logic       issue_ok;
    logic       pay_issue;

    assign occ = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, s1_valid_reg};
    assign pop = out_valid_reg && !out_stall;
    assign issue_ok  = (occ < 2'd2) || (occ == 2'd2 && pop);
    assign pay_issue = left_reg != '0 && issue_ok;
    assign take_ok   = left_reg == '0 && issue_ok;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (pay_issue)
            rdata_reg <= mem[{bank_reg, idx_reg}];
    end

    always_comb
    begin
        s1_next = s1_reg;
        if (start)
        begin
            s1_next.item_kind    = 1'b0;
            s1_next.frame_ok     = verdict.ok;
            s1_next.error_code   = verdict.err;
            s1_next.message_kind = verdict.mk;
            s1_next.service_id   = verdict.sid;
            s1_next.status_word  = verdict.st;
            s1_next.payload_byte = 8'd0;
            s1_next.run_last     = verdict.last;
        end
        else if (pay_issue)
        begin
            s1_next.item_kind    = 1'b1;
            s1_next.frame_ok     = 1'b1;
            s1_next.error_code   = hfv_pkg::ERR_NONE;
            s1_next.message_kind = mk_reg;
            s1_next.service_id   = sid_reg;
            s1_next.status_word  = 32'd0;
            s1_next.payload_byte = 8'd0;
            s1_next.run_last     = left_reg == hfv_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        s1_item = s1_reg;
        if (s1_pay_reg)
            s1_item.payload_byte = rdata_reg;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = s1_valid_reg;
                skid_next       = s1_item;
            end
            else
            begin
                out_valid_next = s1_valid_reg;
                out_next       = s1_item;
            end
        end
        else if (s1_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_next       = s1_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            idx_reg        <= '0;
            bank_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_pay_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= start || pay_issue;
            s1_pay_reg     <= pay_issue;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (start)
            begin
                left_reg <= verdict.n;
                idx_reg  <= '0;
                bank_reg <= verdict.bank;
            end
            else if (pay_issue)
            begin
                left_reg <= left_reg - hfv_pkg::CNT_W'(1);
                idx_reg  <= idx_reg + hfv_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
        if (start)
        begin
            mk_reg  <= verdict.mk;
            sid_reg <= verdict.sid;
        end
    end

    assign out_valid = out_valid_reg;
    assign item      = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/handshake_frame_validator.sv =====
// Output path: the verdict is registered in the s1 stage, then in the output or skid register;
// payload bytes follow at one per cycle from the payload RAM when the output is not stalled.
// Throughput: one frame byte per cycle; the last byte of a frame waits until every payload
// read of the previous frame has been issued and the output pipeline has room.
// Reset: asynchronous, active low; clears configuration to defaults, frame state, output
// valids. The payload RAM is not cleared.
`default_nettype none
module handshake_frame_validator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  byte_in,
    input  wire logic        frame_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             item_kind,
    output logic             frame_ok,
    output logic [2:0]       error_code,
    output logic [1:0]       message_kind,
    output logic [7:0]       service_id,
    output logic [31:0]      status_word,
    output logic [7:0]       payload_byte,
    output logic             run_last
);

    hfv_pkg::cfg_t     cfg;
    hfv_pkg::verdict_t verdict;
    hfv_pkg::wr_t      wr;
    hfv_pkg::item_t    item;
    logic              take_ok;
    logic              start;

    hfv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hfv_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .byte_in   (byte_in),
        .frame_end (frame_end),
        .take_ok   (take_ok),
        .start     (start),
        .verdict   (verdict),
        .wr        (wr)
    );

    hfv_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .start     (start),
        .verdict   (verdict),
        .take_ok   (take_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .item      (item)
    );

    assign item_kind    = item.item_kind;
    assign frame_ok     = item.frame_ok;
    assign error_code   = item.error_code;
    assign message_kind = item.message_kind;
    assign service_id   = item.service_id;
    assign status_word  = item.status_word;
    assign payload_byte = item.payload_byte;
    assign run_last     = item.run_last;

endmodule
`default_nettype wire

// ===== rtl/core/hfv_check.sv =====
`default_nettype none
module hfv_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        frame_end,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        item_kind,
    input wire logic        frame_ok,
    input wire logic [2:0]  error_code,
    input wire logic [1:0]  message_kind,
    input wire logic [7:0]  service_id,
    input wire logic [31:0] status_word,
    input wire logic [7:0]  payload_byte,
    input wire logic        run_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(item_kind) && $stable(payload_byte)
            && $stable(error_code) && $stable(status_word) && $stable(run_last))
        else $error("output transfer changed while stalled");

    a_mid_frame_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !frame_end |-> !in_stall)
        else $error("byte inside a frame was stalled");

    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind |-> frame_ok && error_code == 3'd0 && status_word == 32'd0)
        else $error("payload item from a failed frame");

    a_fail_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_ok |-> !item_kind && run_last && error_code != 3'd0
            && message_kind == 2'd0 && service_id == 8'd0 && status_word == 32'd0)
        else $error("failed verdict malformed");

    a_ok_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !item_kind && frame_ok |-> error_code == 3'd0 && payload_byte == 8'd0)
        else $error("passing verdict carries an error");

endmodule

bind handshake_frame_validator hfv_check u_hfv_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_kind    (item_kind),
    .frame_ok     (frame_ok),
    .error_code   (error_code),
    .message_kind (message_kind),
    .service_id   (service_id),
    .status_word  (status_word),
    .payload_byte (payload_byte),
    .run_last     (run_last)
);
`default_nettype wire
